### hw/rtl/scsa_pkg.sv
// scsa_pkg: shared constants of the size class slot allocator
// field widths, default sizing, request kinds and status codes
// no dependencies
package scsa_pkg;

    // field widths of the request and result ports
    localparam int KIND_W   = 1;
    localparam int BYTES_W  = 16;
    localparam int ADDR_W   = 21;
    localparam int CLASS_W  = 3;
    localparam int STATUS_W = 3;

    // default sizing
    localparam int NUM_CLASSES_DEF  = 8;
    localparam int MIN_SLOT_LOG_DEF = 3;
    localparam int SLOTS_LOG_DEF    = 8;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 3'd4;

endpackage

### hw/rtl/size_class_slot_allocator.sv
// size_class_slot_allocator: top level of the power-of-two pool allocator
// sequencer, per-class counters and free-stack memory
// depends on scsa_pkg, scsa_class_unit, scsa_ram
//
// Each request is an allocate (size in bytes) or a free (byte address). A request is taken
// at a clock edge with start high and busy low, and busy stays high until the result is
// ready. The result shows on o_granted_address, o_size_class and o_status for exactly one
// cycle with o_valid high; the receiver cannot stall it, so it must take every strobe.
// A new request may be taken in the strobe cycle. Timing is set by the class scan, which
// runs one shared comparator over the classes from the smallest up, one class a cycle:
// a request that lands in class c keeps busy high through the scan up to c, the counter
// update and the address build when it grants a slot (a pop also reads the free stack in
// that time); a free or an exhausted class ends in S_ACT with no address build, and a size
// above the largest class or an address outside every region keeps busy high for a scan
// of every class. After reset the block is ready at once: the free stack needs no clearing,
// since only entries below a class's depth are read.
module size_class_slot_allocator #(
    parameter int NUM_CLASSES  = scsa_pkg::NUM_CLASSES_DEF,
    parameter int MIN_SLOT_LOG = scsa_pkg::MIN_SLOT_LOG_DEF,
    parameter int SLOTS_LOG    = scsa_pkg::SLOTS_LOG_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [scsa_pkg::KIND_W-1:0]   i_kind,
    input  logic [scsa_pkg::BYTES_W-1:0]  i_request_bytes,
    input  logic [scsa_pkg::ADDR_W-1:0]   i_slot_address,
    output logic                          o_valid,
    output logic [scsa_pkg::ADDR_W-1:0]   o_granted_address,
    output logic [scsa_pkg::CLASS_W-1:0]  o_size_class,
    output logic [scsa_pkg::STATUS_W-1:0] o_status
);
    import scsa_pkg::*;

    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int CNT_W   = SLOTS_LOG + 1;
    localparam int SPAN_W  = MIN_SLOT_LOG + SLOTS_LOG + NUM_CLASSES;
    // internal address word: wide enough for every region and for the port address
    localparam int WORD_W  = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
    localparam int DEPTH   = NUM_CLASSES << SLOTS_LOG;
    localparam int RAM_A_W = CLS_W + SLOTS_LOG;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_ACT   = 2'd2;
    localparam logic [1:0] S_GRANT = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [BYTES_W-1:0]    r_bytes, n_bytes;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [CLS_W-1:0]      r_cls, n_cls;
    logic                  r_pop, n_pop;
    logic [SLOTS_LOG-1:0]  r_slot, n_slot;
    logic [CNT_W-1:0]      r_depth [NUM_CLASSES];
    logic [CNT_W-1:0]      n_depth [NUM_CLASSES];
    logic [CNT_W-1:0]      r_bump [NUM_CLASSES];
    logic [CNT_W-1:0]      n_bump [NUM_CLASSES];

    // result register
    logic                  r_valid, n_valid;
    logic [ADDR_W-1:0]     r_gaddr, n_gaddr;
    logic [CLASS_W-1:0]    r_scls, n_scls;
    logic [STATUS_W-1:0]   r_status, n_status;

    // class unit
    logic                  cls_hit;
    logic [WORD_W-1:0]     cls_base;
    logic [WORD_W-1:0]     cls_size;

    // free stack port
    logic                  mem_we;
    logic                  mem_re;
    logic [SLOTS_LOG-1:0]  mem_widx;
    logic [SLOTS_LOG-1:0]  mem_ridx;
    logic [SLOTS_LOG-1:0]  mem_wdata;
    logic [SLOTS_LOG-1:0]  mem_rdata;

    // datapath helpers
    logic [WORD_W-1:0]     free_off;
    logic [SLOTS_LOG-1:0]  free_slot;
    logic                  free_misaligned;
    logic [CNT_W-1:0]      depth_cur;
    logic [CNT_W-1:0]      depth_dec;
    logic [CNT_W-1:0]      bump_cur;
    logic [SLOTS_LOG-1:0]  grant_slot;
    logic [WORD_W-1:0]     grant_addr;

    scsa_class_unit #(
        .NUM_CLASSES  (NUM_CLASSES),
        .MIN_SLOT_LOG (MIN_SLOT_LOG),
        .SLOTS_LOG    (SLOTS_LOG),
        .WORD_W       (WORD_W),
        .CLS_W        (CLS_W)
    ) u_cls (
        .i_kind  (r_kind),
        .i_cls   (r_cls),
        .i_bytes (r_bytes),
        .i_addr  (r_addr),
        .o_hit   (cls_hit),
        .o_base  (cls_base),
        .o_size  (cls_size)
    );

    // one stack of SLOTS entries per class, addressed {class, depth}
    scsa_ram #(
        .WIDTH  (SLOTS_LOG),
        .DEPTH  (DEPTH),
        .ADDR_W (RAM_A_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({r_cls, mem_widx}),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr ({r_cls, mem_ridx}),
        .o_rdata (mem_rdata)
    );

    // free path: offset inside the region, alignment and slot index
    assign free_off        = WORD_W'(r_addr) - cls_base;
    assign free_slot       = SLOTS_LOG'((free_off >> MIN_SLOT_LOG) >> r_cls);
    assign free_misaligned = |(free_off & (cls_size - WORD_W'(1)));

    assign depth_cur = r_depth[r_cls];
    assign depth_dec = depth_cur - CNT_W'(1);
    assign bump_cur  = r_bump[r_cls];

    // grant path: popped slot comes straight from the memory read register
    assign grant_slot = r_pop ? mem_rdata : r_slot;
    assign grant_addr = cls_base + ((WORD_W'(grant_slot) << MIN_SLOT_LOG) << r_cls);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_bytes   = r_bytes;
        n_addr    = r_addr;
        n_cls     = r_cls;
        n_pop     = r_pop;
        n_slot    = r_slot;
        n_depth   = r_depth;
        n_bump    = r_bump;
        n_valid   = 1'b0;
        n_gaddr   = r_gaddr;
        n_scls    = r_scls;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_widx  = depth_cur[SLOTS_LOG-1:0];
        mem_ridx  = depth_dec[SLOTS_LOG-1:0];
        mem_wdata = free_slot;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_bytes = i_request_bytes;
                    n_addr  = i_slot_address;
                    n_cls   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // smallest class first; first hit is the class
                if (cls_hit) begin
                    n_state = S_ACT;
                end else if (r_cls == CLS_W'(NUM_CLASSES - 1)) begin
                    n_valid  = 1'b1;
                    n_gaddr  = '0;
                    n_scls   = '0;
                    n_status = (r_kind == KIND_ALLOC) ? ST_TOO_LARGE : ST_NOT_OWNED;
                    n_state  = S_IDLE;
                end else begin
                    n_cls = r_cls + CLS_W'(1);
                end
            end
            S_ACT: begin
                n_gaddr = '0;
                n_scls  = CLASS_W'(r_cls);
                if (r_kind == KIND_ALLOC) begin
                    if (depth_cur != '0) begin
                        // pop: read the top entry; S_GRANT builds the address from the read data
                        n_depth[r_cls] = depth_dec;
                        mem_re         = 1'b1;
                        n_pop          = 1'b1;
                        n_state        = S_GRANT;
                    end else if (!bump_cur[SLOTS_LOG]) begin
                        // never-used slot from the bump counter
                        n_slot        = bump_cur[SLOTS_LOG-1:0];
                        n_bump[r_cls] = bump_cur + CNT_W'(1);
                        n_pop         = 1'b0;
                        n_state       = S_GRANT;
                    end else begin
                        n_valid  = 1'b1;
                        n_status = ST_EXHAUSTED;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (free_misaligned) begin
                        n_status = ST_NOT_OWNED;
                    end else if (depth_cur[SLOTS_LOG]) begin
                        n_status = ST_STACK_FULL;
                    end else begin
                        mem_we         = 1'b1;
                        n_depth[r_cls] = depth_cur + CNT_W'(1);
                        n_status       = ST_OK;
                    end
                end
            end
            S_GRANT: begin
                n_valid  = 1'b1;
                n_gaddr  = ADDR_W'(grant_addr);
                n_scls   = CLASS_W'(r_cls);
                n_status = ST_OK;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_depth[i] <= '0;
                r_bump[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_depth <= n_depth;
            r_bump  <= n_bump;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_bytes  <= n_bytes;
        r_addr   <= n_addr;
        r_cls    <= n_cls;
        r_pop    <= n_pop;
        r_slot   <= n_slot;
        r_gaddr  <= n_gaddr;
        r_scls   <= n_scls;
        r_status <= n_status;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_granted_address = r_gaddr;
    assign o_size_class      = r_scls;
    assign o_status          = r_status;

endmodule

### hw/rtl/scsa_ram.sv
// scsa_ram: generic one-write one-read memory with registered read data
// no dependencies
module scsa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/scsa_class_unit.sv
// scsa_class_unit: shared class compare unit, one class per cycle
// tests a size against a class or an address against a region limit
// depends on scsa_pkg
module scsa_class_unit #(
    parameter int NUM_CLASSES  = scsa_pkg::NUM_CLASSES_DEF,
    parameter int MIN_SLOT_LOG = scsa_pkg::MIN_SLOT_LOG_DEF,
    parameter int SLOTS_LOG    = scsa_pkg::SLOTS_LOG_DEF,
    parameter int WORD_W       = scsa_pkg::ADDR_W,
    parameter int CLS_W        = $clog2(NUM_CLASSES)
) (
    input  logic [scsa_pkg::KIND_W-1:0]  i_kind,
    input  logic [CLS_W-1:0]             i_cls,
    input  logic [scsa_pkg::BYTES_W-1:0] i_bytes,
    input  logic [scsa_pkg::ADDR_W-1:0]  i_addr,
    output logic                         o_hit,
    output logic [WORD_W-1:0]            o_base,
    output logic [WORD_W-1:0]            o_size
);
    import scsa_pkg::*;

    localparam int REGION_SH = MIN_SLOT_LOG + SLOTS_LOG;

    logic [WORD_W-1:0] one_w;
    logic [WORD_W-1:0] last_byte;
    logic [WORD_W-1:0] op_a;
    logic [WORD_W-1:0] op_b;

    assign one_w = WORD_W'(1);

    // slot bytes and region base of the class
    assign o_size = (one_w << MIN_SLOT_LOG) << i_cls;
    assign o_base = ((one_w << i_cls) - one_w) << REGION_SH;

    // last byte of the region; regions are packed upward from zero
    assign last_byte = ((((one_w << 1) << i_cls) - one_w) << REGION_SH) - one_w;

    assign op_a = (i_kind == KIND_ALLOC) ? WORD_W'(i_bytes) : WORD_W'(i_addr);
    assign op_b = (i_kind == KIND_ALLOC) ? o_size : last_byte;

    // the single shared comparator
    assign o_hit = (op_a <= op_b);

endmodule

### hw/rtl/scsa_checker.sv
// scsa_checker: port-level checks of the allocator's request/result timing
// bound to size_class_slot_allocator; depends on scsa_pkg
module scsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [scsa_pkg::ADDR_W-1:0]   o_granted_address,
    input logic [scsa_pkg::STATUS_W-1:0] o_status
);
    import scsa_pkg::*;

    // a taken request makes the block busy
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    // busy only drops when a result is presented
    a_result_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("busy dropped without a result");

    // a strobe always lands in an idle cycle, which never raises it, so strobes never abut
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held two cycles");

    // nothing granted means address zero
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_granted_address == '0))
        else $error("nonzero address on failed request");

endmodule

bind size_class_slot_allocator scsa_checker u_scsa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_granted_address (o_granted_address),
    .o_status          (o_status)
);

### verif/testbench.sv
// testbench for size_class_slot_allocator: directed and random allocate/free requests,
// each result checked field by field against an in-bench slot ledger
// depends on scsa_pkg and the size_class_slot_allocator rtl
`timescale 1ns / 1ps

module testbench;
    import scsa_pkg::*;

    // block sizing, matches the default parameters of u_dut
    localparam int NUM_CL      = NUM_CLASSES_DEF;
    localparam int MIN_LOG     = MIN_SLOT_LOG_DEF;
    localparam int SLOT_LOG    = SLOTS_LOG_DEF;
    localparam int SLOTS       = 1 << SLOT_LOG;
    // first byte past the largest class region
    localparam int WINDOW_END  = ((1 << NUM_CL) - 1) << (MIN_LOG + SLOT_LOG);

    // run length: the last CALM_ITEMS requests go in with no sender gaps
    localparam int TOTAL_ITEMS = 1800;
    localparam int CALM_ITEMS  = 250;
    // the worst request scans every class, then updates and builds an address; this is plenty
    localparam int TAIL_CYCLES = 20;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [CLASS_W-1:0]  cls;
        logic [STATUS_W-1:0] status;
    } t_grant;

    // start byte of a class region, regions packed back to back
    function automatic int unsigned region_base(int c);
        return ((1 << c) - 1) << (MIN_LOG + SLOT_LOG);
    endfunction

    function automatic int unsigned slot_start(int c, int unsigned slot);
        return region_base(c) + (slot << (MIN_LOG + c));
    endfunction

    // ledger of per-class free stacks and bump counters, plus the
    // expected results still waiting for their strobe
    class slot_ledger;
        int unsigned depth[NUM_CL];
        int unsigned bumped[NUM_CL];
        int unsigned stack_mem[NUM_CL][SLOTS];
        t_grant      awaited_q[$];
        int          errors;

        function new();
            foreach (depth[c]) begin
                depth[c]  = 0;
                bumped[c] = 0;
            end
            foreach (stack_mem[c, s]) stack_mem[c][s] = 0;
            errors = 0;
        endfunction

        // update the ledger for an accepted request and queue its result
        function t_grant note_request(logic [KIND_W-1:0] kind,
                                      logic [BYTES_W-1:0] bytes,
                                      logic [ADDR_W-1:0] addr);
            t_grant      r;
            int          found;
            int unsigned slot;
            int unsigned off;
            int unsigned sh;
            r     = '0;
            found = -1;
            if (kind == KIND_ALLOC) begin
                for (int c = 0; c < NUM_CL; c++) begin
                    if (found < 0 && (32'd1 << (MIN_LOG + c)) >= bytes) found = c;
                end
                if (found < 0) begin
                    r.status = ST_TOO_LARGE;
                end else begin
                    r.cls = found[CLASS_W-1:0];
                    if (depth[found] > 0) begin
                        depth[found]--;
                        slot     = stack_mem[found][depth[found]];
                        r.status = ST_OK;
                        r.addr   = ADDR_W'(slot_start(found, slot));
                    end else if (bumped[found] < SLOTS) begin
                        slot     = bumped[found];
                        bumped[found]++;
                        r.status = ST_OK;
                        r.addr   = ADDR_W'(slot_start(found, slot));
                    end else begin
                        r.status = ST_EXHAUSTED;
                    end
                end
            end else begin
                for (int c = 0; c < NUM_CL; c++) begin
                    if (found < 0 && addr >= region_base(c) &&
                        addr < region_base(c) + (32'd1 << (MIN_LOG + SLOT_LOG + c)))
                        found = c;
                end
                r.status = ST_NOT_OWNED;
                if (found >= 0) begin
                    r.cls = found[CLASS_W-1:0];
                    sh    = MIN_LOG + found;
                    off   = addr - region_base(found);
                    if ((off & ((32'd1 << sh) - 1)) != 0) begin
                        r.status = ST_NOT_OWNED;
                    end else if (depth[found] >= SLOTS) begin
                        r.status = ST_STACK_FULL;
                    end else begin
                        stack_mem[found][depth[found]] = (off >> sh) & (SLOTS - 1);
                        depth[found]++;
                        r.status = ST_OK;
                    end
                end
            end
            awaited_q.push_back(r);
            return r;
        endfunction

        function void check_result(logic [ADDR_W-1:0] addr, logic [CLASS_W-1:0] cls,
                                   logic [STATUS_W-1:0] status);
            t_grant e;
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected result addr %h class %0d status %0d",
                         $time, addr, cls, status);
                errors++;
                return;
            end
            e = awaited_q.pop_front();
            if (addr !== e.addr) begin
                $display("%0t: granted_address expected %h got %h", $time, e.addr, addr);
                errors++;
            end
            if (cls !== e.cls) begin
                $display("%0t: size_class expected %0d got %0d", $time, e.cls, cls);
                errors++;
            end
            if (status !== e.status) begin
                $display("%0t: status expected %0d got %0d", $time, e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [KIND_W-1:0]   i_kind = '0;
    logic [BYTES_W-1:0]  i_request_bytes = '0;
    logic [ADDR_W-1:0]   i_slot_address = '0;
    logic                o_valid;
    logic [ADDR_W-1:0]   o_granted_address;
    logic [CLASS_W-1:0]  o_size_class;
    logic [STATUS_W-1:0] o_status;

    slot_ledger          ledger = new();
    int unsigned         granted_q[$];   // addresses handed out; some are kept after their free, for double frees
    int                  sent = 0;
    bit                  gaps_on = 1'b1;

    size_class_slot_allocator u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_request_bytes   (i_request_bytes),
        .i_slot_address    (i_slot_address),
        .o_valid           (o_valid),
        .o_granted_address (o_granted_address),
        .o_size_class      (o_size_class),
        .o_status          (o_status)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // every strobe must be taken, there is no way to hold results off;
    // values read here are the ones the edge captures
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            ledger.check_result(o_granted_address, o_size_class, o_status);
    end

    // drive one request from the falling edge and hold it until it is taken;
    // start stays high into the next request when no gap follows
    task automatic send_request(logic [KIND_W-1:0] kind, logic [BYTES_W-1:0] bytes,
                                logic [ADDR_W-1:0] addr);
        t_grant r;
        @(negedge i_clk);
        start           <= 1'b1;
        i_kind          <= kind;
        i_request_bytes <= bytes;
        i_slot_address  <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = ledger.note_request(kind, bytes, addr);
        if (kind == KIND_ALLOC && r.status == ST_OK) granted_q.push_back(r.addr);
        sent++;
    endtask

    // random sender gap, never in the closing stretch of the run
    task automatic maybe_gap();
        int n;
        if (gaps_on && sent < TOTAL_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 17);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // hold the sender back until every outstanding result has come out
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (ledger.awaited_q.size() != 0) @(posedge i_clk);
    endtask

    // a size that lands exactly in class c
    function automatic int unsigned size_for_class(int c);
        if (c == 0) return $urandom_range(0, 1 << MIN_LOG);
        return $urandom_range((1 << (MIN_LOG + c - 1)) + 1, 1 << (MIN_LOG + c));
    endfunction

    // run of n allocates into one class; n above its free slots runs it dry
    task automatic flood_alloc(int c, int n);
        repeat (n) begin
            send_request(KIND_ALLOC, BYTES_W'(size_for_class(c)), ADDR_W'($urandom()));
            maybe_gap();
        end
    endtask

    // run of n aligned frees into one class; n above its stack room fills it
    task automatic flood_free(int c, int n);
        repeat (n) begin
            send_request(KIND_FREE, BYTES_W'($urandom()),
                         ADDR_W'(slot_start(c, $urandom_range(0, SLOTS - 1))));
            maybe_gap();
        end
    endtask

    // one request from the mixed traffic: mostly sane allocates and frees of
    // granted slots, some double frees, misaligned and foreign addresses
    task automatic mixed_request();
        int          roll;
        int          c;
        int          idx;
        int unsigned a;
        roll = $urandom_range(0, 99);
        c    = $urandom_range(0, NUM_CL - 1);
        if (roll < 45) begin
            case ($urandom_range(0, 9))
                0:       send_request(KIND_ALLOC, BYTES_W'($urandom()), ADDR_W'($urandom()));
                1:       send_request(KIND_ALLOC, BYTES_W'($urandom_range(1025, 65535)),
                                      ADDR_W'($urandom()));
                default: send_request(KIND_ALLOC, BYTES_W'(size_for_class(c)),
                                      ADDR_W'($urandom()));
            endcase
        end else begin
            roll = $urandom_range(0, 9);
            a    = slot_start(c, $urandom_range(0, SLOTS - 1));
            if (roll < 6 && granted_q.size() != 0) begin
                idx = $urandom_range(0, granted_q.size() - 1);
                a   = granted_q[idx];
                // roll 0 keeps the address around for a later double free
                if (roll != 0) granted_q.delete(idx);
            end else if (roll == 6) begin
                a = a + $urandom_range(1, (1 << (MIN_LOG + c)) - 1);
            end else if (roll == 8) begin
                a = $urandom() & ((1 << ADDR_W) - 1);
            end else if (roll == 9) begin
                a = $urandom_range(WINDOW_END, (1 << ADDR_W) - 1);
            end
            send_request(KIND_FREE, BYTES_W'($urandom()), ADDR_W'(a));
        end
        maybe_gap();
    endtask

    initial begin
        int n;
        int mode;
        int k;

        // synchronous reset
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: class boundaries, oversize, pops, double free,
        // misaligned and foreign frees, last slot of the top class
        send_request(KIND_ALLOC, 16'd0, 21'd0);
        send_request(KIND_ALLOC, 16'd1, 21'd0);
        send_request(KIND_ALLOC, 16'd8, 21'd0);
        send_request(KIND_ALLOC, 16'd9, 21'd0);
        send_request(KIND_ALLOC, 16'd16, 21'd0);
        send_request(KIND_ALLOC, 16'd17, 21'd0);
        send_request(KIND_ALLOC, 16'd512, 21'd0);
        send_request(KIND_ALLOC, 16'd513, 21'd0);
        send_request(KIND_ALLOC, 16'd1024, 21'd0);
        send_request(KIND_ALLOC, 16'd1025, 21'd0);
        send_request(KIND_ALLOC, 16'hFFFF, 21'h1FFFFF);
        send_request(KIND_FREE, 16'd0, 21'd8);
        send_request(KIND_FREE, 16'd0, 21'd8);
        send_request(KIND_ALLOC, 16'd4, 21'd0);
        send_request(KIND_ALLOC, 16'd5, 21'd0);
        send_request(KIND_FREE, 16'd0, 21'd12);
        send_request(KIND_FREE, 16'd0, ADDR_W'(region_base(1) + 4));
        send_request(KIND_FREE, 16'd0, ADDR_W'(WINDOW_END));
        send_request(KIND_FREE, 16'hFFFF, 21'h1FFFFF);
        send_request(KIND_FREE, 16'd0, ADDR_W'(slot_start(NUM_CL - 1, SLOTS - 1)));
        send_request(KIND_ALLOC, 16'd1000, 21'd0);
        send_request(KIND_FREE, 16'd0, ADDR_W'(region_base(1) - 1));
        send_request(KIND_FREE, 16'd0, 21'd0);
        send_request(KIND_ALLOC, 16'd128, 21'd0);
        wait_drained();

        // exhaust one class and overfill another early, so both corner
        // cases are reached whatever the random bursts do later
        flood_alloc($urandom_range(0, NUM_CL - 1), 300);
        flood_free($urandom_range(0, NUM_CL - 1), 300);

        while (sent < TOTAL_ITEMS) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            mode    = $urandom_range(0, 9);
            n       = $urandom_range(20, 120);
            if (n > TOTAL_ITEMS - sent) n = TOTAL_ITEMS - sent;
            if (mode == 0) begin
                flood_alloc($urandom_range(0, NUM_CL - 1), n);
            end else if (mode == 1) begin
                flood_free($urandom_range(0, NUM_CL - 1), n);
            end else begin
                repeat (n) mixed_request();
            end
            if (sent < TOTAL_ITEMS - CALM_ITEMS && $urandom_range(0, 7) == 0)
                wait_drained();
        end

        // drain, then a tail to catch any stray strobe
        @(negedge i_clk);
        start <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && ledger.awaited_q.size() != 0; k++)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.awaited_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, ledger.awaited_q.size());
            ledger.errors++;
        end
        if (ledger.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hard stop, several times the slowest legal run
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
